/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property: holds at every sampled edge outside reset.
`define PBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Next-cycle implication: when pre holds, post must hold at the next sampled edge.
`define PBC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) \
		else $error(msg);

`endif

/* rtl/pbc_pkg.sv */
// Shared types and constants for the pixel blend and channel unit.
// No dependencies; imported by the lane, merge and top-level modules.
package pbc_pkg;

	localparam int PIX_W = 8;
	localparam int CH_W  = 2;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

	typedef enum logic [2:0] {
		MODE_MULTIPLY = 3'd0,
		MODE_SUBTRACT = 3'd1,
		MODE_SCREEN   = 3'd2,
		MODE_OVERLAY  = 3'd3,
		MODE_ADD      = 3'd4,
		MODE_SCALE    = 3'd5,
		MODE_CLONE    = 3'd6,
		MODE_SET      = 3'd7
	} blend_mode_t;

	localparam logic [CH_W-1:0] CH_BLUE  = 2'd0;
	localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
	localparam logic [CH_W-1:0] CH_RED   = 2'd2;
	localparam logic [CH_W-1:0] CH_NONE  = 2'd3;

	// Configuration register indexes on the write port
	localparam logic [1:0] REG_BLEND_MODE     = 2'd0;
	localparam logic [1:0] REG_PIXEL_CHANNEL  = 2'd1;
	localparam logic [1:0] REG_CHANNEL_AMOUNT = 2'd2;

	typedef struct packed {
		blend_mode_t       mode;
		logic [CH_W-1:0]   channel;
		logic [PIX_W-1:0]  amount;
	} pbc_cfg_t;

	// Per-stage load enables from the pipeline control
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} pbc_adv_t;

endpackage

/* rtl/pbc_lane.sv */
// One color lane: product, divide-by-255 estimate and correction.
// Depends on pbc_pkg; three copies run side by side in the top level.
module pbc_lane import pbc_pkg::*; (
	input  logic             clk,
	input  pbc_cfg_t         cfg,
	input  pbc_adv_t         adv,
	input  logic             lane_sel,
	input  logic [PIX_W-1:0] a,
	input  logic [PIX_W-1:0] b,
	output logic [PIX_W-1:0] res
);

	// stage 1 combinational
	logic             inv_c;
	logic [PIX_W-1:0] mul_x, mul_y;
	logic [PIX_W:0]   sum_c;
	logic [PIX_W-1:0] direct_c;

	logic [2*PIX_W-1:0] prod_s1;
	logic [PIX_W-1:0]   direct_s1;
	logic               use_div_s1, invert_s1, k4_s1, scale_s1;

	// stage 2 combinational
	logic [18:0]      num_c;
	logic [17:0]      y_c;
	logic [25:0]      est_c;
	logic [PIX_W-1:0] direct2_c;

	logic [17:0]      y_s2;
	logic [9:0]       q0_s2;
	logic [PIX_W-1:0] direct_s2;
	logic             use_div_s2, invert_s2;

	// stage 3 combinational
	logic [17:0]      q255_c;
	logic [17:0]      rem_c;
	logic [9:0]       q_c;

	assign inv_c = (cfg.mode == MODE_SCREEN) || ((cfg.mode == MODE_OVERLAY) && b[PIX_W-1]);
	assign sum_c = {1'b0, a} + {1'b0, cfg.amount};

	always_comb begin
		if (cfg.mode == MODE_SCALE) begin
			mul_x = a;
			mul_y = cfg.amount;
		end else if (inv_c) begin
			mul_x = ~a;
			mul_y = ~b;
		end else begin
			mul_x = a;
			mul_y = b;
		end
	end

	always_comb begin
		unique case (cfg.mode)
			MODE_SUBTRACT: direct_c = (b > a) ? '0 : a - b;
			MODE_ADD:      direct_c = (lane_sel && sum_c[PIX_W]) ? PIX_MAX :
			                          (lane_sel ? sum_c[PIX_W-1:0] : a);
			MODE_SET:      direct_c = lane_sel ? b : a;
			default:       direct_c = a;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s1) begin
			prod_s1    <= mul_x * mul_y;
			direct_s1  <= direct_c;
			use_div_s1 <= (cfg.mode == MODE_MULTIPLY) || (cfg.mode == MODE_SCREEN) ||
			              (cfg.mode == MODE_OVERLAY);
			invert_s1  <= inv_c;
			k4_s1      <= (cfg.mode == MODE_OVERLAY);
			scale_s1   <= (cfg.mode == MODE_SCALE) && lane_sel;
		end
	end

	// round(k*prod/510) = floor(floor((k*prod + 255)/2) / 255)
	assign num_c = (k4_s1 ? {1'b0, prod_s1, 2'b00} : {2'b00, prod_s1, 1'b0}) + 19'd255;
	assign y_c   = num_c[18:1];
	// y*257/65536 is floor(y/255) or one less
	assign est_c = {y_c, 8'b0} + {8'b0, y_c};

	assign direct2_c = scale_s1 ?
		((|prod_s1[2*PIX_W-1:PIX_W]) ? PIX_MAX : prod_s1[PIX_W-1:0]) : direct_s1;

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			y_s2       <= y_c;
			q0_s2      <= est_c[25:16];
			direct_s2  <= direct2_c;
			use_div_s2 <= use_div_s1;
			invert_s2  <= invert_s1;
		end
	end

	// correct the estimate by one where the remainder reaches 255
	assign q255_c = {q0_s2, 8'b0} - {8'b0, q0_s2};
	assign rem_c  = y_s2 - q255_c;
	assign q_c    = q0_s2 + {9'b0, (rem_c >= 18'd255)};

	assign res = use_div_s2 ? (invert_s2 ? ~q_c[PIX_W-1:0] : q_c[PIX_W-1:0]) : direct_s2;

endmodule

/* rtl/pbc_merge.sv */
// Merge stage: combines the three lane results into the output register.
// Depends on pbc_pkg; handles the clone mode, which crosses lanes.
module pbc_merge import pbc_pkg::*; (
	input  logic             clk,
	input  pbc_cfg_t         cfg,
	input  logic             ld,
	input  logic [PIX_W-1:0] lane_blue,
	input  logic [PIX_W-1:0] lane_green,
	input  logic [PIX_W-1:0] lane_red,
	input  logic             last_in,
	output logic [PIX_W-1:0] out_blue,
	output logic [PIX_W-1:0] out_green,
	output logic [PIX_W-1:0] out_red,
	output logic             last_out
);

	logic             clone_en;
	logic [PIX_W-1:0] clone_val;
	logic [PIX_W-1:0] blue_q, green_q, red_q;
	logic             last_q;

	always_comb begin
		clone_en = (cfg.mode == MODE_CLONE);
		unique case (cfg.channel)
			CH_BLUE:  clone_val = lane_blue;
			CH_GREEN: clone_val = lane_green;
			CH_RED:   clone_val = lane_red;
			CH_NONE: begin
				clone_en  = 1'b0;
				clone_val = lane_blue;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			blue_q  <= clone_en ? clone_val : lane_blue;
			green_q <= clone_en ? clone_val : lane_green;
			red_q   <= clone_en ? clone_val : lane_red;
			last_q  <= last_in;
		end
	end

	assign out_blue  = blue_q;
	assign out_green = green_q;
	assign out_red   = red_q;
	assign last_out  = last_q;

endmodule

/* rtl/pixel_blend_and_channel_unit.sv */
// Pixel blend and channel unit: three-stage pipeline, one lane per color.
// An accepted pixel pair passes through the stage 1, stage 2 and output registers.
// Throughput: one pair per cycle while out_stall is low; each stage loads when empty or draining.
// Reset (arst_n low) clears the stage valid bits and the three config registers.
module pixel_blend_and_channel_unit import pbc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [PIX_W-1:0] wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [PIX_W-1:0] first_blue,
	input  logic [PIX_W-1:0] first_green,
	input  logic [PIX_W-1:0] first_red,
	input  logic [PIX_W-1:0] second_blue,
	input  logic [PIX_W-1:0] second_green,
	input  logic [PIX_W-1:0] second_red,
	input  logic             last_pixel,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PIX_W-1:0] out_blue,
	output logic [PIX_W-1:0] out_green,
	output logic [PIX_W-1:0] out_red,
	output logic             last_out
);

	pbc_cfg_t  cfg_q;
	pbc_adv_t  adv;
	logic      v_s1, v_s2, out_valid_q;
	logic      last_s1, last_s2;
	logic [PIX_W-1:0] res_blue, res_green, res_red;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode    <= MODE_MULTIPLY;
			cfg_q.channel <= CH_BLUE;
			cfg_q.amount  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BLEND_MODE:     cfg_q.mode    <= blend_mode_t'(wr_data[2:0]);
				REG_PIXEL_CHANNEL:  cfg_q.channel <= wr_data[CH_W-1:0];
				REG_CHANNEL_AMOUNT: cfg_q.amount  <= wr_data;
				default: ;
			endcase
		end
	end

	// a stage advances when it is empty or the stage after it advances
	always_comb begin
		adv.ld_s3 = !out_valid_q || !out_stall;
		adv.ld_s2 = !v_s2 || adv.ld_s3;
		adv.ld_s1 = !v_s1 || adv.ld_s2;
	end

	assign in_stall  = !adv.ld_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv.ld_s1) v_s1 <= in_valid;
			if (adv.ld_s2) v_s2 <= v_s1;
			if (adv.ld_s3) out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s1) last_s1 <= last_pixel;
		if (adv.ld_s2) last_s2 <= last_s1;
	end

	pbc_lane u_lane_blue (
		.clk      (clk),
		.cfg      (cfg_q),
		.adv      (adv),
		.lane_sel (cfg_q.channel == CH_BLUE),
		.a        (first_blue),
		.b        (second_blue),
		.res      (res_blue)
	);

	pbc_lane u_lane_green (
		.clk      (clk),
		.cfg      (cfg_q),
		.adv      (adv),
		.lane_sel (cfg_q.channel == CH_GREEN),
		.a        (first_green),
		.b        (second_green),
		.res      (res_green)
	);

	pbc_lane u_lane_red (
		.clk      (clk),
		.cfg      (cfg_q),
		.adv      (adv),
		.lane_sel (cfg_q.channel == CH_RED),
		.a        (first_red),
		.b        (second_red),
		.res      (res_red)
	);

	pbc_merge u_merge (
		.clk        (clk),
		.cfg        (cfg_q),
		.ld         (adv.ld_s3),
		.lane_blue  (res_blue),
		.lane_green (res_green),
		.lane_red   (res_red),
		.last_in    (last_s2),
		.out_blue   (out_blue),
		.out_green  (out_green),
		.out_red    (out_red),
		.last_out   (last_out)
	);

endmodule

/* rtl/pbc_checker.sv */
// Port-level checker for the pixel blend and channel unit, bound to the top.
// Depends on assert_macros.svh; sees the handshake ports and the output payload.
`include "assert_macros.svh"

module pbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_blue,
	input logic [7:0] out_green,
	input logic [7:0] out_red,
	input logic       last_out
);

	// hold a stalled transaction on the output
	`PBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_blue) && $stable(out_green) && $stable(out_red) && $stable(last_out), "stalled output transaction changed")

	// input backs up only when every stage is full and the output is stalled
	`PBC_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with room in pipeline")

	// an accepted transaction reaches the output register when out_stall stays low behind it
	`PBC_ASSERT(a_latency, in_valid && !in_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "accepted transaction did not appear on output")

endmodule

bind pixel_blend_and_channel_unit pbc_checker u_pbc_checker (.*);
